>>> hdl/word_clock_phrase_indices_assert.svh
// assertion macros shared by the word clock phrase rtl
// no dependencies; files that assert include this header by name
`ifndef WORD_CLOCK_PHRASE_INDICES_ASSERT_SVH
`define WORD_CLOCK_PHRASE_INDICES_ASSERT_SVH

`ifndef SYNTH
// checked on aclk, quiet while aresetn is low
`define WCPI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked on aclk at every edge, reset included
`define WCPI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define WCPI_ASSERT(lbl, prop, msg)
`define WCPI_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hdl/wcpi_pkg.sv
// types, word tables and helpers for the word clock phrase builder
// no dependencies; used by wcpi_phrase and word_clock_phrase_indices
`timescale 1ns / 1ps

package wcpi_pkg;

    localparam int MaxWords = 7;

    typedef logic [5:0] word_t;   // two's complement, all ones means no word

    typedef struct packed {
        word_t [MaxWords-1:0] words;
        logic  [2:0]          len;
    } phrase_t;

    // configuration register indexes
    localparam logic CFG_LANGUAGE  = 1'b0;
    localparam logic CFG_SAY_INTRO = 1'b1;

    // language codes
    localparam logic LANG_CATALAN = 1'b0;
    localparam logic LANG_SPANISH = 1'b1;

    localparam word_t NO_WORD = 6'h3F;

    localparam word_t CAT_HOUR_WORD [12] = '{6'd20, 6'd14, 6'd16, 6'd17, 6'd19, 6'd27,
                                            6'd23, 6'd18, 6'd21, 6'd22, 6'd24, 6'd15};
    localparam word_t CAS_HOUR_WORD [12] = '{6'd15, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8,
                                            6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14};
    localparam word_t CAS_MIN_WORD [12]  = '{NO_WORD, 6'd21, 6'd19, 6'd23, 6'd18, 6'd20,
                                            6'd22, 6'd20, 6'd18, 6'd23, 6'd19, 6'd21};
    localparam word_t CAT_QART_ART [4]   = '{NO_WORD, 6'd2, 6'd3, 6'd5};
    localparam word_t CAT_QART_WORD [4]  = '{NO_WORD, 6'd7, 6'd8, 6'd8};
    localparam word_t CAT_STEP_WORD [3]  = '{6'd9, NO_WORD, 6'd10};
    localparam word_t CAT_STEP_FIVE [3]  = '{6'd11, NO_WORD, 6'd11};
    localparam word_t CAT_MISC [7]       = '{6'd1, 6'd4, NO_WORD, 6'd13, 6'd12, NO_WORD,
                                            6'd0};
    localparam word_t CAT_HSTEP_WORD [3] = '{6'd25, NO_WORD, 6'd26};
    localparam word_t CAT_HSTEP_FIVE [3] = '{6'd27, NO_WORD, 6'd27};
    localparam word_t CAS_AND_LESS [2]   = '{6'd16, 6'd17};
    localparam word_t CAS_MISC [4]       = '{6'd0, 6'd1, 6'd2, 6'd3};

    // reduce a value below 36 modulo 12
    function automatic logic [3:0] mod12(input logic [5:0] v);
        logic [5:0] t;
        begin
            t = (v >= 6'd24) ? v - 6'd24 : v;
            t = (t >= 6'd12) ? t - 6'd12 : t;
            mod12 = t[3:0];
        end
    endfunction

    // reduce a value below 120 modulo 60
    function automatic logic [5:0] mod60(input logic [6:0] v);
        logic [6:0] t;
        begin
            t = (v >= 7'd60) ? v - 7'd60 : v;
            mod60 = t[5:0];
        end
    endfunction

endpackage

>>> hdl/wcpi_phrase.sv
// combinational phrase builder: hour and minute to an ordered word list
// depends on wcpi_pkg
`timescale 1ns / 1ps

module wcpi_phrase (
    input  logic [4:0]       hour,
    input  logic [5:0]       minute,
    input  logic             language,
    input  logic             say_intro,
    output wcpi_pkg::phrase_t phrase
);
    import wcpi_pkg::*;

    // catalan
    logic [6:0] cat_sum;
    logic [5:0] cat_adv;
    logic [1:0] cat_q;
    logic [5:0] cat_rem;
    logic [1:0] cat_c;
    logic       cat_bump;
    logic [3:0] cat_h;
    logic [3:0] cat_hn;

    // spanish
    logic [5:0]  cas_m;
    logic [9:0]  cas_prod;
    logic [3:0]  cas_r;
    logic        cas_late;
    logic [3:0]  cas_h;

    word_t      body [6];
    logic [2:0] body_len;
    word_t      intro_word;

    always_comb begin
        cat_sum = {1'b0, minute} + 7'd5;
        cat_adv = mod60(cat_sum);
        if (cat_adv >= 6'd45) begin
            cat_q = 2'd3;
            cat_rem = cat_adv - 6'd45;
        end else if (cat_adv >= 6'd30) begin
            cat_q = 2'd2;
            cat_rem = cat_adv - 6'd30;
        end else if (cat_adv >= 6'd15) begin
            cat_q = 2'd1;
            cat_rem = cat_adv - 6'd15;
        end else begin
            cat_q = 2'd0;
            cat_rem = cat_adv;
        end
        cat_c = (cat_rem >= 6'd10) ? 2'd2 : ((cat_rem >= 6'd5) ? 2'd1 : 2'd0);
        cat_bump = (cat_q == 2'd0) && (cat_c != 2'd2) && (minute > 6'd45);
        cat_h = mod12({1'b0, hour} + {5'd0, cat_bump});
        cat_hn = (cat_h == 4'd11) ? 4'd0 : cat_h + 4'd1;
    end

    always_comb begin
        cas_m = mod60({1'b0, minute});
        // divide by five: 13/64 is exact for values below 60
        cas_prod = {4'd0, cas_m} * 10'd13;
        cas_r = cas_prod[9:6];
        cas_late = cas_r > 4'd6;
        cas_h = mod12({1'b0, hour} + {5'd0, cas_late});
    end

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            body[i] = NO_WORD;
        end
        body_len = 3'd0;
        intro_word = NO_WORD;
        if (language == LANG_CATALAN) begin
            intro_word = CAT_MISC[6];
            if (cat_q == 2'd0) begin
                body[0] = (cat_h == 4'd1) ? CAT_MISC[0] : CAT_MISC[1];
                if (cat_c == 2'd1) begin
                    body[1] = CAT_HOUR_WORD[cat_h];
                    body[2] = CAT_MISC[2];
                    body_len = 3'd3;
                end else begin
                    // five o'clock takes its own form before the step words
                    body[1] = (cat_h == 4'd5) ? CAT_STEP_FIVE[0] : CAT_HOUR_WORD[cat_h];
                    body[2] = CAT_HSTEP_WORD[cat_c];
                    body[3] = CAT_HSTEP_FIVE[cat_c];
                    body_len = 3'd4;
                end
            end else begin
                body[0] = CAT_QART_ART[cat_q];
                body[1] = CAT_QART_WORD[cat_q];
                body[2] = CAT_STEP_WORD[cat_c];
                body[3] = CAT_STEP_FIVE[cat_c];
                body[4] = (cat_hn == 4'd1 || cat_hn == 4'd11) ? CAT_MISC[3] : CAT_MISC[4];
                body[5] = CAT_HOUR_WORD[cat_hn];
                body_len = 3'd6;
            end
        end else begin
            intro_word = (cas_h == 4'd1) ? CAS_MISC[0] : CAS_MISC[1];
            body[0] = (cas_h == 4'd1) ? CAS_MISC[2] : CAS_MISC[3];
            body[1] = CAS_HOUR_WORD[cas_h];
            if (cas_r != 4'd0) begin
                body[2] = CAS_AND_LESS[cas_late];
                body[3] = CAS_MIN_WORD[cas_r];
                body_len = 3'd4;
            end else begin
                body_len = 3'd2;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MaxWords; i++) begin
            if (say_intro) begin
                if (i == 0) begin
                    phrase.words[i] = intro_word;
                end else begin
                    phrase.words[i] = body[i-1];
                end
            end else if (i < 6) begin
                phrase.words[i] = body[i];
            end else begin
                phrase.words[i] = NO_WORD;
            end
        end
        phrase.len = body_len + {2'd0, say_intro};
    end

endmodule

>>> hdl/word_clock_phrase_indices.sv
// top level of the word clock phrase builder: stream ports, config, word serializer
// depends on wcpi_pkg, wcpi_phrase and word_clock_phrase_indices_assert.svh
`timescale 1ns / 1ps

// Word clock phrase builder. Each input transaction carries an hour (0..23, taken
// modulo 12) and a minute; the block answers with 2 to 7 output transactions, one
// panel word index each, in reading order, with tlast on the final word. An index of
// -1 (all ones) means no word and is sent like any other. Register 0 selects the
// language (0 Catalan, 1 Spanish), register 1 adds the leading "it is" word; write
// them only while the block is idle. Timing: an accepted time is held in an input
// register, the whole phrase is built combinationally from it and loaded into a
// phrase register, which then emits one word per cycle while m_tready is high.
// The output port is the limit. The next time is taken and its phrase prepared
// while the current phrase is still draining, so phrases follow one another with
// no gap.

module word_clock_phrase_indices (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic        cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [4:0] hour, [10:5] minute, rest zero
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [5:0] word_index (signed), rest zero
    output logic        m_tlast     // last word of the phrase
);
    import wcpi_pkg::*;

    `include "word_clock_phrase_indices_assert.svh"

    // configuration registers
    logic language_reg;
    logic say_intro_reg;

    // input register
    logic       in_valid_reg;
    logic [4:0] hour_reg;
    logic [5:0] minute_reg;

    // phrase register and read pointer
    phrase_t    phrase;
    phrase_t    ph_reg;
    logic       ph_valid_reg;
    logic [2:0] ph_idx_reg;
    logic [2:0] ph_idx_next;

    logic s_accept;
    logic pop;
    logic done;
    logic load;
    logic is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            language_reg <= LANG_CATALAN;
            say_intro_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_LANGUAGE:  language_reg <= cfg_wdata;
                CFG_SAY_INTRO: say_intro_reg <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    wcpi_phrase u_phrase (
        .hour      (hour_reg),
        .minute    (minute_reg),
        .language  (language_reg),
        .say_intro (say_intro_reg),
        .phrase    (phrase)
    );

    // handshake bookkeeping
    assign is_last  = (ph_idx_reg == ph_reg.len - 3'd1);
    assign pop      = m_tvalid && m_tready;
    assign done     = pop && is_last;
    // the built phrase moves over once the phrase register is free or draining its last word
    assign load     = in_valid_reg && (!ph_valid_reg || done);
    assign s_tready = !in_valid_reg || load;
    assign s_accept = s_tvalid && s_tready;
    assign ph_idx_next = ph_idx_reg + 3'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            hour_reg   <= s_tdata[4:0];
            minute_reg <= s_tdata[10:5];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_valid_reg <= 1'b0;
            ph_idx_reg   <= 3'd0;
        end else if (load) begin
            ph_valid_reg <= 1'b1;
            ph_idx_reg   <= 3'd0;
        end else if (done) begin
            ph_valid_reg <= 1'b0;
            ph_idx_reg   <= 3'd0;
        end else if (pop) begin
            ph_idx_reg   <= ph_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ph_reg <= phrase;
        end
    end

    // output side, straight from the phrase register
    assign m_tvalid = ph_valid_reg;
    assign m_tdata  = {2'b00, ph_reg.words[ph_idx_reg]};
    assign m_tlast  = is_last;

    `WCPI_ASSERT(a_idx_in_phrase, m_tvalid |-> (ph_idx_reg < ph_reg.len), "word pointer past phrase end")
    `WCPI_ASSERT(a_len_range, m_tvalid |-> (ph_reg.len >= 3'd2 && ph_reg.len <= 3'd7), "bad phrase length")
    `WCPI_ASSERT(a_phrase_continues, (pop && !m_tlast) |=> m_tvalid, "phrase dropped before its last word")
    `WCPI_ASSERT(a_accept_held, s_accept |=> in_valid_reg, "accepted time lost")
    `WCPI_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (!m_tvalid && !in_valid_reg), "busy after reset")

endmodule
